// ----- design/adsr_envelope_shaper_assert.svh -----
// assertion macros for the adsr envelope shaper
`ifndef ADSR_ENVELOPE_SHAPER_ASSERT_SVH
`define ADSR_ENVELOPE_SHAPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ADSR_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

`define ADSR_ASSERT(label, prop, msg) \
    `ADSR_ASSERT_CLK(label, clk, rst_n, prop, msg)

`else

`define ADSR_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)

`define ADSR_ASSERT(label, prop, msg)

`endif

`endif

// ----- design/adsr_pkg.sv -----
package adsr_pkg;

    localparam int POSITION_BITS  = 20;
    localparam int NOTE_BITS      = 20;
    localparam int LEN_BITS       = 16;
    localparam int LEVEL_BITS     = 9;
    localparam int SAMPLE_BITS    = 8;
    localparam int Q_FRAC_BITS    = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = NOTE_BITS;

    localparam int UNITY_GAIN  = 2 ** Q_FRAC_BITS;
    localparam int ROUND_BIAS  = UNITY_GAIN - 1;
    localparam int SAMPLE_MAX  = 127;
    localparam int SAMPLE_MIN  = -128;

    localparam int AD_BITS      = LEN_BITS + 1;
    localparam int PHASES_BITS  = LEN_BITS + 2;
    localparam int BOUND_BITS   = NOTE_BITS + 1;
    localparam int CMP_BITS     = ((POSITION_BITS > BOUND_BITS) ? POSITION_BITS : BOUND_BITS) + 1;
    localparam int NUM_BITS     = LEN_BITS + LEVEL_BITS;
    localparam int DIV_STEPS    = LEVEL_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
    localparam int PROD_BITS    = SAMPLE_BITS + LEVEL_BITS + 1;
    localparam int SCALE_BITS   = PROD_BITS - Q_FRAC_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NOTE    = 3'd4;

    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_SUSTAIN = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    typedef struct packed {
        logic load_in;
        logic bound_a;
        logic bound_b;
        logic select;
        logic mult;
        logic div_init;
        logic div_step;
        logic scale;
        logic emit;
    } adsr_cmd_t;

    typedef struct packed {
        logic need_div;
    } adsr_stat_t;

endpackage

// ----- design/adsr_in_if.sv -----
interface adsr_in_if;
    import adsr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ----- design/adsr_out_if.sv -----
interface adsr_out_if;
    import adsr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          note_end;

    modport source (output valid, output sample_out, output note_end, input ready);
    modport sink (input valid, input sample_out, input note_end, output ready);
endinterface

// ----- design/adsr_envelope_shaper.sv -----
// Linear ADSR envelope: each signed 8-bit sample is multiplied by a Q8 gain
// (256 = unity) picked from the position within the note and saturated
// to -128..127; the last sample of each note carries note_end. One sample
// is worked at a time. In attack, decay and release the gain is formed
// by a restoring divider, one bit per cycle (9 steps); in sustain or
// past the release the divider is skipped. The finished beat waits in
// an output register, so the next sample is accepted while it is still
// unread.
module adsr_envelope_shaper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    adsr_in_if.sink                             samples,
    adsr_out_if.source                          results
);
    import adsr_pkg::*;

    adsr_cmd_t  cmd;
    adsr_stat_t stat;

    adsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    adsr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (samples.sample_in),
        .cmd        (cmd),
        .stat       (stat),
        .sample_out (results.sample_out),
        .note_end   (results.note_end)
    );

endmodule

// ----- design/adsr_ctrl.sv -----
`include "adsr_envelope_shaper_assert.svh"

module adsr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output adsr_pkg::adsr_cmd_t  cmd,
    input  adsr_pkg::adsr_stat_t stat
);
    import adsr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BND1  = 4'd1;
    localparam logic [3:0] S_BND2  = 4'd2;
    localparam logic [3:0] S_SEL   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_BND1;
                end
            end
            S_BND1:
            begin
                cmd.bound_a = 1'b1;
                state_next  = S_BND2;
            end
            S_BND2:
            begin
                cmd.bound_b = 1'b1;
                state_next  = S_SEL;
            end
            S_SEL:
            begin
                cmd.select = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = stat.need_div ? S_DINIT : S_SCALE;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ADSR_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_reg == S_BND1), "accepted beat did not start work")
    `ADSR_ASSERT(a_emit_fills_out, cmd.emit |=> out_valid_reg, "emitted beat not presented")
    `ADSR_ASSERT(a_div_count, (state_reg == S_DIV) |-> (cnt_reg < DIV_CNT_BITS'(DIV_STEPS)), "divider ran past its steps")

endmodule

// ----- design/adsr_dp.sv -----
module adsr_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [adsr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in,
    input  adsr_pkg::adsr_cmd_t                  cmd,
    output adsr_pkg::adsr_stat_t                 stat,
    output logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                 note_end
);
    import adsr_pkg::*;

    localparam logic [LEVEL_BITS-1:0] UNITY = LEVEL_BITS'(UNITY_GAIN);

    logic [LEN_BITS-1:0]      attack_len_reg;
    logic [LEN_BITS-1:0]      decay_len_reg;
    logic [LEN_BITS-1:0]      release_len_reg;
    logic [LEVEL_BITS-1:0]    sustain_level_reg;
    logic [NOTE_BITS-1:0]     note_len_reg;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [AD_BITS-1:0]       sum_ad_reg;
    logic [PHASES_BITS-1:0]   phases_reg;
    logic [BOUND_BITS-1:0]    b3_reg, b3_next;
    logic [BOUND_BITS-1:0]    b4_reg, b4_next;
    logic [2:0]               phase_reg, phase_next;
    logic [LEN_BITS-1:0]      op_a_reg, op_a_next;
    logic [LEVEL_BITS-1:0]    op_b_reg, op_b_next;
    logic [LEN_BITS-1:0]      divisor_reg, divisor_next;
    logic [NUM_BITS-1:0]      num_reg;
    logic [LEN_BITS-1:0]      rem_reg, rem_next;
    logic [LEVEL_BITS-1:0]    lo_reg, lo_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg, sample_out_next;
    logic                     note_end_reg, last;

    logic [LEVEL_BITS-1:0]    sus_lvl;
    logic [CMP_BITS-1:0]      p_ext, off_decay, off_release;
    logic [BOUND_BITS-1:0]    n_ext, ph_ext;
    logic [LEN_BITS:0]        trial;
    logic                     ge;
    logic [LEVEL_BITS-1:0]    gain;
    logic signed [PROD_BITS-1:0]  adj;
    logic signed [SCALE_BITS-1:0] y;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg    <= '0;
            decay_len_reg     <= '0;
            release_len_reg   <= '0;
            sustain_level_reg <= UNITY;
            note_len_reg      <= NOTE_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ATTACK:  attack_len_reg    <= cfg_data[LEN_BITS-1:0];
                REG_DECAY:   decay_len_reg     <= cfg_data[LEN_BITS-1:0];
                REG_RELEASE: release_len_reg   <= cfg_data[LEN_BITS-1:0];
                REG_SUSTAIN: sustain_level_reg <= cfg_data[LEVEL_BITS-1:0];
                REG_NOTE:    note_len_reg      <= cfg_data[NOTE_BITS-1:0];
                default:     ;
            endcase
        end
    end

    assign sus_lvl = (sustain_level_reg > UNITY) ? UNITY : sustain_level_reg;

    // phase boundaries: sustain end and release end
    always_comb
    begin
        n_ext  = BOUND_BITS'(note_len_reg);
        ph_ext = BOUND_BITS'(phases_reg);
        if (n_ext > ph_ext)
        begin
            b3_next = n_ext - BOUND_BITS'(release_len_reg);
            b4_next = n_ext;
        end
        else
        begin
            b3_next = BOUND_BITS'(sum_ad_reg);
            b4_next = ph_ext;
        end
    end

    // phase select and divider operands
    always_comb
    begin
        p_ext        = CMP_BITS'(pos_reg);
        off_decay    = p_ext - CMP_BITS'(attack_len_reg);
        off_release  = p_ext - CMP_BITS'(b3_reg);
        phase_next   = PH_DONE;
        op_a_next    = '0;
        op_b_next    = '0;
        divisor_next = release_len_reg;
        priority if (p_ext < CMP_BITS'(attack_len_reg))
        begin
            phase_next   = PH_ATTACK;
            op_a_next    = p_ext[LEN_BITS-1:0];
            op_b_next    = UNITY;
            divisor_next = attack_len_reg;
        end
        else if (p_ext < CMP_BITS'(sum_ad_reg))
        begin
            phase_next   = PH_DECAY;
            op_a_next    = off_decay[LEN_BITS-1:0];
            op_b_next    = UNITY - sus_lvl;
            divisor_next = decay_len_reg;
        end
        else if (p_ext < CMP_BITS'(b3_reg))
        begin
            phase_next = PH_SUSTAIN;
        end
        else if (p_ext < CMP_BITS'(b4_reg))
        begin
            phase_next = PH_RELEASE;
            op_a_next  = release_len_reg - off_release[LEN_BITS-1:0];
            op_b_next  = sus_lvl;
        end
        else
        begin
            phase_next = PH_DONE;
        end
    end

    assign stat.need_div = (phase_reg == PH_ATTACK) || (phase_reg == PH_DECAY)
                           || (phase_reg == PH_RELEASE);

    // restoring divider, one quotient bit per step
    always_comb
    begin
        trial    = {rem_reg, lo_reg[LEVEL_BITS-1]};
        ge       = trial >= {1'b0, divisor_reg};
        rem_next = ge ? LEN_BITS'(trial - {1'b0, divisor_reg}) : trial[LEN_BITS-1:0];
        lo_next  = {lo_reg[LEVEL_BITS-2:0], ge};
    end

    // gain and scaling
    always_comb
    begin
        unique case (phase_reg)
            PH_ATTACK:  gain = lo_reg;
            PH_DECAY:   gain = UNITY - lo_reg;
            PH_SUSTAIN: gain = sus_lvl;
            PH_RELEASE: gain = lo_reg;
            default:    gain = '0;
        endcase
        prod_next = PROD_BITS'(x_reg) * PROD_BITS'($signed({1'b0, gain}));
    end

    // round toward zero and saturate
    always_comb
    begin
        adj = (prod_reg < 0) ? prod_reg + PROD_BITS'(ROUND_BIAS) : prod_reg;
        y   = $signed(adj[PROD_BITS-1:Q_FRAC_BITS]);
        if (y > $signed(SCALE_BITS'(SAMPLE_MAX)))
        begin
            sample_out_next = SAMPLE_BITS'(SAMPLE_MAX);
        end
        else if (y < $signed(SCALE_BITS'(SAMPLE_MIN)))
        begin
            sample_out_next = SAMPLE_BITS'(SAMPLE_MIN);
        end
        else
        begin
            sample_out_next = y[SAMPLE_BITS-1:0];
        end
        last     = CMP_BITS'({1'b0, pos_reg} + (POSITION_BITS + 1)'(1))
                   >= CMP_BITS'(note_len_reg);
        pos_next = last ? '0 : pos_reg + POSITION_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.emit)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= sample_in;
        end
        if (cmd.bound_a)
        begin
            sum_ad_reg <= AD_BITS'(attack_len_reg) + AD_BITS'(decay_len_reg);
            phases_reg <= PHASES_BITS'(attack_len_reg) + PHASES_BITS'(decay_len_reg)
                          + PHASES_BITS'(release_len_reg);
        end
        if (cmd.bound_b)
        begin
            b3_reg <= b3_next;
            b4_reg <= b4_next;
        end
        if (cmd.select)
        begin
            phase_reg   <= phase_next;
            op_a_reg    <= op_a_next;
            op_b_reg    <= op_b_next;
            divisor_reg <= divisor_next;
        end
        if (cmd.mult)
        begin
            num_reg <= NUM_BITS'(op_a_reg) * NUM_BITS'(op_b_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[NUM_BITS-1 -: LEN_BITS];
            lo_reg  <= num_reg[LEVEL_BITS-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
        end
        if (cmd.scale)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.emit)
        begin
            sample_out_reg <= sample_out_next;
            note_end_reg   <= last;
        end
    end

    assign sample_out = sample_out_reg;
    assign note_end   = note_end_reg;

endmodule
